/* rtl/drt_pkg.sv */
// download request table package: transaction types, command and status codes
// no dependencies
package drt_pkg;

	localparam int KEY_W = 64;
	localparam int HGT_W = 32;
	localparam int OWN_W = 7;
	localparam int CNT_W = 7;
	localparam int ENTRY_W = 4 * KEY_W + HGT_W;
	localparam int DEF_TABLE_DEPTH = 64;

	localparam logic [2:0] CMD_ADD      = 3'd0;
	localparam logic [2:0] CMD_NEXT     = 3'd1;
	localparam logic [2:0] CMD_ASSIGN   = 3'd2;
	localparam logic [2:0] CMD_COMPLETE = 3'd3;
	localparam logic [2:0] CMD_UNASSIGN = 3'd4;
	localparam logic [2:0] CMD_UNOWN    = 3'd5;
	localparam logic [2:0] CMD_CONTAINS = 3'd6;
	localparam logic [2:0] CMD_NONE     = 3'd7;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_PRESENT  = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	localparam logic [HGT_W-1:0] HGT_MAX = '1;

	typedef struct packed {
		logic [2:0]       cmd;
		logic [KEY_W-1:0] key_word0;
		logic [KEY_W-1:0] key_word1;
		logic [KEY_W-1:0] key_word2;
		logic [KEY_W-1:0] key_word3;
		logic [HGT_W-1:0] height;
		logic [OWN_W-1:0] owner_id;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [KEY_W-1:0] out_word0;
		logic [KEY_W-1:0] out_word1;
		logic [KEY_W-1:0] out_word2;
		logic [KEY_W-1:0] out_word3;
		logic [HGT_W-1:0] out_height;
		logic [CNT_W-1:0] used_total;
		logic [CNT_W-1:0] pending_total;
		logic [CNT_W-1:0] inflight_total;
	} rsp_t;

endpackage

/* rtl/drt_mem.sv */
// simple dual-port synchronous memory, one write and one read port
// read data registered; no dependencies
module drt_mem #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/download_request_table.sv */
// download request table: one command at a time; each command sweeps the entry memory,
// then passes through the drain, finish and result states before the next one is taken
// a new command is taken while the previous result still waits in the output register
// reset clears valid and busy bits and all counts; key, height and owner memories
// hold garbage until written and are never read from an invalid slot
module download_request_table #(
	parameter int TABLE_DEPTH = drt_pkg::DEF_TABLE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  drt_pkg::req_t in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output drt_pkg::rsp_t out_data
);
	import drt_pkg::*;

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SWEEP,
		S_DRAIN,
		S_FINISH,
		S_RESULT
	} state_t;

	state_t state_q;

	// latched command transaction
	req_t req_q;

	// control state
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [TABLE_DEPTH-1:0] busy_q;
	logic [CW-1:0] used_q, pend_q, infl_q;
	logic [IW-1:0] idx_q;
	logic          vld_s1;
	logic [IW-1:0] idx_s1;

	// sweep trackers
	logic          hit_q;
	logic [IW-1:0] hit_idx_q;
	logic          free_q;
	logic [IW-1:0] free_idx_q;
	logic          found_q;
	logic [HGT_W-1:0] best_h_q;
	logic [4*KEY_W-1:0] best_key_q;

	// result held between finish and output load
	logic [1:0]         res_st_q;
	logic [4*KEY_W-1:0] res_key_q;
	logic [HGT_W-1:0]   res_h_q;

	rsp_t out_q;
	logic out_valid_q;

	// memory ports
	logic               ent_we;
	logic [ENTRY_W-1:0] ent_rdata;
	logic               own_we;
	logic [OWN_W-1:0]   own_rdata;
	logic [IW-1:0]      rd_addr;

	logic [4*KEY_W-1:0] in_key;
	logic [4*KEY_W-1:0] rd_key;
	logic [HGT_W-1:0]   rd_h;
	logic               cur_v, cur_b;
	logic               key_match, own_match;
	logic               add_ok, hit_busy;

	assign in_key   = {req_q.key_word3, req_q.key_word2, req_q.key_word1, req_q.key_word0};
	assign rd_key   = ent_rdata[ENTRY_W-1:HGT_W];
	assign rd_h     = ent_rdata[HGT_W-1:0];
	assign rd_addr  = idx_q;
	assign cur_v    = valid_q[idx_s1];
	assign cur_b    = busy_q[idx_s1];
	assign key_match = vld_s1 && cur_v && (rd_key == in_key);
	assign own_match = vld_s1 && cur_v && cur_b && (own_rdata == req_q.owner_id);
	assign hit_busy = busy_q[hit_idx_q];

	// add succeeds on no duplicate, room left, and a free slot seen in the sweep
	assign add_ok = !hit_q && (used_q < FULL_CNT) && free_q;
	assign ent_we = (state_q == S_FINISH) && (req_q.cmd == CMD_ADD) && add_ok;
	assign own_we = (state_q == S_FINISH) && (req_q.cmd == CMD_ASSIGN) && hit_q;

	drt_mem #(.DEPTH(TABLE_DEPTH), .WIDTH(ENTRY_W)) u_ent_mem (
		.clk   (clk),
		.we    (ent_we),
		.waddr (free_idx_q),
		.wdata ({in_key, req_q.height}),
		.raddr (rd_addr),
		.rdata (ent_rdata)
	);

	drt_mem #(.DEPTH(TABLE_DEPTH), .WIDTH(OWN_W)) u_own_mem (
		.clk   (clk),
		.we    (own_we),
		.waddr (hit_idx_q),
		.wdata (req_q.owner_id),
		.raddr (rd_addr),
		.rdata (own_rdata)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// control: state machine, slot flags, counts, output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			busy_q      <= '0;
			used_q      <= '0;
			pend_q      <= '0;
			infl_q      <= '0;
			idx_q       <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			vld_s1 <= 1'b0;

			// release every busy slot of one owner as the sweep passes it
			if (req_q.cmd == CMD_UNOWN && own_match) begin
				busy_q[idx_s1] <= 1'b0;
				if (infl_q != '0) begin
					infl_q <= infl_q - CW'(1);
				end
				pend_q <= pend_q + CW'(1);
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						idx_q   <= '0;
						state_q <= S_SWEEP;
					end
				end
				S_SWEEP: begin
					vld_s1 <= 1'b1;
					if (idx_q == LAST_IDX) begin
						state_q <= S_DRAIN;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				S_DRAIN: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					case (req_q.cmd)
						CMD_ADD: begin
							if (add_ok) begin
								valid_q[free_idx_q] <= 1'b1;
								busy_q[free_idx_q]  <= 1'b0;
								used_q <= used_q + CW'(1);
								pend_q <= pend_q + CW'(1);
							end
						end
						CMD_ASSIGN: begin
							if (hit_q) begin
								if (!hit_busy) begin
									if (pend_q != '0) begin
										pend_q <= pend_q - CW'(1);
									end
									infl_q <= infl_q + CW'(1);
								end
								busy_q[hit_idx_q] <= 1'b1;
							end
						end
						CMD_COMPLETE: begin
							if (hit_q) begin
								if (hit_busy) begin
									if (infl_q != '0) begin
										infl_q <= infl_q - CW'(1);
									end
								end else if (pend_q != '0) begin
									pend_q <= pend_q - CW'(1);
								end
								valid_q[hit_idx_q] <= 1'b0;
								busy_q[hit_idx_q]  <= 1'b0;
								if (used_q != '0) begin
									used_q <= used_q - CW'(1);
								end
							end
						end
						CMD_UNASSIGN: begin
							if (hit_q && hit_busy) begin
								busy_q[hit_idx_q] <= 1'b0;
								if (infl_q != '0) begin
									infl_q <= infl_q - CW'(1);
								end
								pend_q <= pend_q + CW'(1);
							end
						end
						default: begin
						end
					endcase
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					// output register free or draining this cycle
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath: command latch, sweep trackers, result
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			req_q    <= in_data;
			hit_q    <= 1'b0;
			free_q   <= 1'b0;
			found_q  <= 1'b0;
			best_h_q <= HGT_MAX;
		end

		idx_s1 <= idx_q;

		if (vld_s1) begin
			// first slot holding the key
			if (key_match && !hit_q) begin
				hit_q     <= 1'b1;
				hit_idx_q <= idx_s1;
			end
			// lowest free slot
			if (!cur_v && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= idx_s1;
			end
			// least height among pending slots, strict compare keeps the lowest slot
			if (cur_v && !cur_b && rd_h < best_h_q) begin
				found_q    <= 1'b1;
				best_h_q   <= rd_h;
				best_key_q <= rd_key;
			end
		end

		if (state_q == S_FINISH) begin
			res_key_q <= '0;
			res_h_q   <= '0;
			res_st_q  <= ST_OK;
			case (req_q.cmd)
				CMD_ADD: begin
					if (hit_q) begin
						res_st_q <= ST_PRESENT;
					end else if (!add_ok) begin
						res_st_q <= ST_FULL;
					end
				end
				CMD_NEXT: begin
					if (found_q) begin
						res_key_q <= best_key_q;
						res_h_q   <= best_h_q;
					end else begin
						res_st_q <= ST_NOTFOUND;
					end
				end
				CMD_ASSIGN, CMD_COMPLETE, CMD_UNASSIGN, CMD_CONTAINS: begin
					if (!hit_q) begin
						res_st_q <= ST_NOTFOUND;
					end
				end
				default: begin
				end
			endcase
		end

		if (state_q == S_RESULT && (!out_valid_q || out_ready)) begin
			out_q.status         <= res_st_q;
			out_q.out_word0      <= res_key_q[KEY_W-1:0];
			out_q.out_word1      <= res_key_q[2*KEY_W-1:KEY_W];
			out_q.out_word2      <= res_key_q[3*KEY_W-1:2*KEY_W];
			out_q.out_word3      <= res_key_q[4*KEY_W-1:3*KEY_W];
			out_q.out_height     <= res_h_q;
			out_q.used_total     <= CNT_W'(used_q);
			out_q.pending_total  <= CNT_W'(pend_q);
			out_q.inflight_total <= CNT_W'(infl_q);
		end
	end

endmodule
